/* rtl/msc_pkg.sv */
// Shared types and constants for the message store with cancel match.
// Used by every module under rtl; depends on nothing.
`default_nettype none
package msc_pkg;

  localparam int TBL_DEPTH = 16;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

  localparam logic [31:0] CANCEL_CALL_BIT = 32'h8000_0000;

  localparam logic [2:0] MT_CALL         = 3'd1;
  localparam logic [2:0] MT_SHORT        = 3'd2;
  localparam logic [2:0] MT_CANCEL_CALL  = 3'd3;
  localparam logic [2:0] MT_CANCEL_SHORT = 3'd4;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  msg_type;
    logic [31:0] task_id;
    logic [7:0]  msg_len;
    logic [15:0] body_handle;
    logic [3:0]  index;
  } msc_in_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        found;
    logic        removed;
    logic        dropped_oldest;
    logic        error;
    logic [4:0]  count;
    logic [2:0]  read_type;
    logic [31:0] read_task_id;
    logic [7:0]  read_len;
    logic [15:0] read_handle;
  } msc_out_t;

  // One stored message.
  typedef struct packed {
    logic [2:0]  etype;
    logic [31:0] task_id;
    logic [7:0]  len;
    logic [15:0] handle;
  } entry_t;

  // Per-cell update controls.
  typedef struct packed {
    logic shift_en;  // take the upper neighbor's entry
    logic load_en;   // take the new entry (wins over shift)
  } cell_ctl_t;

  // Search key broadcast to all cells.
  typedef struct packed {
    logic        enable;
    logic [2:0]  mtype;
    logic        set_msb;
    logic [31:0] task_id;
  } match_key_t;

endpackage
`default_nettype wire

/* rtl/msc_cell.sv */
// One slot of the message table: holds an entry, shifts from its upper neighbor.
// Depends on msc_pkg.
`default_nettype none
module msc_cell
  import msc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctl_t  ctl,
  input  wire entry_t     upper,
  input  wire entry_t     wr_entry,
  input  wire match_key_t key,
  output entry_t          entry,
  output logic            hit
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_en) begin
      entry_nxt = wr_entry;
    end else if (ctl.shift_en) begin
      entry_nxt = upper;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  // Compare against the key; the cancel-call form ORs in the top task id bit.
  assign hit = key.enable && (entry_r.etype == key.mtype) &&
               ((entry_r.task_id | (key.set_msb ? CANCEL_CALL_BIT : 32'h0)) == key.task_id);

  assign entry = entry_r;

endmodule
`default_nettype wire

/* rtl/msc_first_hit.sv */
// Priority encoder: lowest (oldest) matching slot of the table.
// Depends on msc_pkg.
`default_nettype none
module msc_first_hit
  import msc_pkg::*;
(
  input  wire logic [TBL_DEPTH-1:0] hits,
  output logic                      any_hit,
  output logic [IDX_W-1:0]          hit_idx
);

  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int k = TBL_DEPTH - 1; k >= 0; k--) begin
      if (hits[k]) begin
        any_hit = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/message_store_with_cancel_match.sv */
// Top level of the message store with cancel match: cell row, search and control.
// Depends on msc_pkg, msc_cell and msc_first_hit.
`default_nettype none
// Age-ordered table of up to 16 messages kept in a row of shift cells, slot 0
// the oldest. A command beat is taken at a clock edge where start is high and
// busy is low; busy then stays high through the execute state, in which every
// cell compares its entry against the key in parallel, the oldest hit is
// picked and the row shifts or loads. The result beat appears on out_data with
// out_valid high for exactly one cycle, starting at the edge where busy falls,
// and a new command can be started in the cycle the result is shown. No new
// command is taken while busy is high, in the execute state (compare, priority
// pick, cell update). The receiver cannot stall: a result beat must be captured
// when out_valid is high, it is not held. Every command yields exactly one beat.
// Removals shift younger entries down and clear the freed top slot; an append
// to a full table drops the oldest entry first.
module message_store_with_cancel_match
  import msc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire msc_in_t in_data,
  output logic         out_valid,
  output msc_out_t     out_data
);

  state_t   state_r, state_nxt;
  msc_in_t  req_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  msc_out_t res_r, res_nxt;
  logic     out_valid_r, out_valid_nxt;

  entry_t     cell_q   [TBL_DEPTH];
  cell_ctl_t  cell_ctl [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] hits;
  match_key_t key;
  entry_t     wr_entry;
  entry_t     rd_entry;

  logic             any_hit;
  logic [IDX_W-1:0] hit_idx;

  // Row update controls, decided in the execute cycle.
  logic             do_shift;
  logic [IDX_W-1:0] shift_pos;
  logic             do_load;
  logic [IDX_W-1:0] load_pos;

  logic full;
  logic idx_ok;
  logic is_cancel;

  // Hold the command while it executes.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_data;
    end
  end

  // Search key from the held command.
  always_comb begin
    key         = '0;
    key.task_id = req_r.task_id;
    is_cancel   = 1'b0;
    if (state_r == ST_EXEC && req_r.cmd == CMD_CHECK) begin
      case (req_r.msg_type)
        MT_CALL, MT_SHORT: begin
          key.enable = 1'b1;
          key.mtype  = req_r.msg_type;
        end
        MT_CANCEL_CALL: begin
          key.enable  = 1'b1;
          key.mtype   = MT_CALL;
          key.set_msb = 1'b1;
          is_cancel   = 1'b1;
        end
        MT_CANCEL_SHORT: begin
          key.enable = 1'b1;
          key.mtype  = MT_SHORT;
          is_cancel  = 1'b1;
        end
        default: begin
          key.enable = 1'b0;
        end
      endcase
    end
  end

  assign wr_entry.etype   = req_r.msg_type;
  assign wr_entry.task_id = req_r.task_id;
  assign wr_entry.len     = req_r.msg_len;
  assign wr_entry.handle  = req_r.body_handle;

  // The cell row: each cell takes its upper neighbor on a shift; the top
  // cell takes zero, which clears the vacated slot.
  for (genvar k = 0; k < TBL_DEPTH; k++) begin : g_cell
    entry_t upper;
    if (k == TBL_DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_q[k+1];
    end

    assign cell_ctl[k].shift_en = do_shift && (IDX_W'(k) >= shift_pos);
    assign cell_ctl[k].load_en  = do_load && (IDX_W'(k) == load_pos);

    msc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl[k]),
      .upper    (upper),
      .wr_entry (wr_entry),
      .key      (key),
      .entry    (cell_q[k]),
      .hit      (hits[k])
    );
  end

  msc_first_hit u_first_hit (
    .hits    (hits),
    .any_hit (any_hit),
    .hit_idx (hit_idx)
  );

  assign rd_entry = cell_q[req_r.index];
  assign full     = (cnt_r == CNT_W'(TBL_DEPTH));
  assign idx_ok   = ({1'b0, req_r.index} < cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    do_shift      = 1'b0;
    shift_pos     = '0;
    do_load       = 1'b0;
    load_pos      = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        res_nxt       = '0;
        case (req_r.cmd)
          CMD_APPEND: begin
            // Full table: drop slot 0, shift all down, load at the top.
            do_shift  = full;
            do_load   = 1'b1;
            load_pos  = full ? IDX_W'(TBL_DEPTH - 1) : cnt_r[IDX_W-1:0];
            cnt_nxt   = full ? cnt_r : cnt_r + CNT_W'(1);
            res_nxt.slot           = 4'(load_pos);
            res_nxt.dropped_oldest = full;
          end
          CMD_CHECK: begin
            if (any_hit) begin
              res_nxt.found = 1'b1;
              res_nxt.slot  = 4'(hit_idx);
              if (is_cancel) begin
                do_shift        = 1'b1;
                shift_pos       = hit_idx;
                cnt_nxt         = cnt_r - CNT_W'(1);
                res_nxt.removed = 1'b1;
              end
            end
          end
          CMD_DELETE: begin
            if (idx_ok) begin
              do_shift        = 1'b1;
              shift_pos       = req_r.index[IDX_W-1:0];
              cnt_nxt         = cnt_r - CNT_W'(1);
              res_nxt.removed = 1'b1;
              res_nxt.slot    = req_r.index;
            end else begin
              res_nxt.error = 1'b1;
            end
          end
          CMD_READ: begin
            if (idx_ok) begin
              res_nxt.slot         = req_r.index;
              res_nxt.read_type    = rd_entry.etype;
              res_nxt.read_task_id = rd_entry.task_id;
              res_nxt.read_len     = rd_entry.len;
              res_nxt.read_handle  = rd_entry.handle;
            end else begin
              res_nxt.error = 1'b1;
            end
          end
          default: begin
            res_nxt.error = 1'b0;
          end
        endcase
        res_nxt.count = 5'(cnt_nxt);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

/* verif/message_store_with_cancel_match_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the message store with cancel match.
// Depends on msc_pkg and the message_store_with_cancel_match top level under rtl.
module message_store_with_cancel_match_tb;
  import msc_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_TAIL    = 150;        // final random beats sent back to back
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 2_000_000;  // far above the slowest legal run

  // Message types that have no name in the package.
  localparam logic [2:0] MT_NONE      = 3'd0;
  localparam logic [2:0] MT_PLAIN     = 3'd5;
  localparam logic [2:0] MT_PLAIN_MAX = 3'd7;

  typedef struct {
    msc_in_t  item;
    bit       has_exp;
    msc_out_t exp;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  msc_in_t  in_data;
  logic     out_valid;
  msc_out_t out_data;

  // Shadow copy of the message table, oldest entry in slot 0.
  entry_t      shadow_tbl [TBL_DEPTH];
  int unsigned shadow_count;

  // Status beats still owed by the block, oldest first.
  msc_out_t    awaited_status [$];
  stim_row_t   directed_rows [$];

  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned full_appends;
  int unsigned cancel_hits;
  int unsigned dup_hits;
  int unsigned index_errors;

  message_store_with_cancel_match u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Hard stop in case a beat never shows up.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Table model
  // ------------------------------------------------------------------

  // Drop one slot, shift the younger entries down and clear the freed top.
  function automatic void shadow_remove(int unsigned pos);
    for (int unsigned k = pos; k + 1 < shadow_count; k++) shadow_tbl[k] = shadow_tbl[k + 1];
    shadow_tbl[shadow_count - 1] = '0;
    shadow_count--;
  endfunction

  // Apply one command beat to the shadow table and return the status it earns.
  function automatic msc_out_t apply_command(msc_in_t c);
    msc_out_t r;
    logic     hit;
    entry_t   e;
    r = '0;
    case (c.cmd)
      CMD_APPEND: begin
        if (shadow_count == TBL_DEPTH) begin
          shadow_remove(0);
          r.dropped_oldest = 1'b1;
        end
        r.slot = shadow_count[IDX_W-1:0];
        shadow_tbl[shadow_count] = '{c.msg_type, c.task_id, c.msg_len, c.body_handle};
        shadow_count++;
      end
      CMD_CHECK: begin
        // Scan from the oldest entry; the first hit wins.
        for (int unsigned k = 0; k < shadow_count && !r.found; k++) begin
          case (c.msg_type)
            MT_CALL, MT_SHORT:
              hit = shadow_tbl[k].etype == c.msg_type && shadow_tbl[k].task_id == c.task_id;
            MT_CANCEL_CALL:
              hit = shadow_tbl[k].etype == MT_CALL &&
                    (shadow_tbl[k].task_id | CANCEL_CALL_BIT) == c.task_id;
            MT_CANCEL_SHORT:
              hit = shadow_tbl[k].etype == MT_SHORT && shadow_tbl[k].task_id == c.task_id;
            default:
              hit = 1'b0;
          endcase
          if (hit) begin
            r.found = 1'b1;
            r.slot  = k[IDX_W-1:0];
            if (c.msg_type == MT_CANCEL_CALL || c.msg_type == MT_CANCEL_SHORT) begin
              shadow_remove(k);
              r.removed = 1'b1;
            end
          end
        end
      end
      CMD_DELETE: begin
        if (c.index < shadow_count) begin
          shadow_remove(c.index);
          r.removed = 1'b1;
          r.slot    = c.index;
        end else begin
          r.error = 1'b1;
        end
      end
      CMD_READ: begin
        if (c.index < shadow_count) begin
          e              = shadow_tbl[c.index];
          r.slot         = c.index;
          r.read_type    = e.etype;
          r.read_task_id = e.task_id;
          r.read_len     = e.len;
          r.read_handle  = e.handle;
        end else begin
          r.error = 1'b1;
        end
      end
      default: r.error = 1'b1;
    endcase
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Status with no read data, for the rows typed in by hand.
  function automatic msc_out_t status(logic [3:0] slot, logic found, logic removed,
                                      logic dropped, logic err, logic [4:0] count);
    return '{slot, found, removed, dropped, err, count, 3'd0, 32'd0, 8'd0, 16'd0};
  endfunction

  function automatic void add_row(msc_in_t item, bit has_exp, msc_out_t exp);
    stim_row_t row;
    row.item    = item;
    row.has_exp = has_exp;
    row.exp     = exp;
    directed_rows.push_back(row);
  endfunction

  // Idle burst ahead of the next beat when allowed, or none.
  function automatic int unsigned idle_gap(bit allow);
    if (allow && $urandom_range(0, 3) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  // Random command, biased toward growing or shrinking the table. Checks mostly
  // aim at a held entry so that duplicates and cancels really hit.
  function automatic msc_in_t random_command(bit filling);
    msc_in_t     c;
    int unsigned pick;
    entry_t      victim;
    c.msg_type    = 3'($urandom_range(0, 7));
    c.task_id     = $urandom;
    c.msg_len     = 8'($urandom);
    c.body_handle = 16'($urandom);
    c.index       = 4'($urandom_range(0, 15));
    pick          = $urandom_range(0, 99);
    if (filling) begin
      c.cmd = (pick < 60) ? CMD_APPEND : (pick < 85) ? CMD_CHECK :
              (pick < 90) ? CMD_DELETE : CMD_READ;
    end else begin
      c.cmd = (pick < 15) ? CMD_APPEND : (pick < 55) ? CMD_CHECK :
              (pick < 85) ? CMD_DELETE : CMD_READ;
    end
    case (c.cmd)
      CMD_APPEND: begin
        // Keep a small pool of task ids so that keys repeat.
        if ($urandom_range(0, 3) != 0) c.msg_type = 3'($urandom_range(1, 2));
        if ($urandom_range(0, 1) != 0) c.task_id = c.task_id & 32'h8000_000F;
      end
      CMD_CHECK: begin
        if (shadow_count != 0 && $urandom_range(0, 9) < 7) begin
          victim    = shadow_tbl[$urandom_range(0, shadow_count - 1)];
          c.task_id = victim.task_id;
          if (victim.etype == MT_CALL) begin
            c.msg_type = $urandom_range(0, 1) ? MT_CALL : MT_CANCEL_CALL;
            if (c.msg_type == MT_CANCEL_CALL) c.task_id = victim.task_id | CANCEL_CALL_BIT;
          end else if (victim.etype == MT_SHORT) begin
            c.msg_type = $urandom_range(0, 1) ? MT_SHORT : MT_CANCEL_SHORT;
          end
        end else if ($urandom_range(0, 1) != 0) begin
          c.task_id = c.task_id & 32'h8000_000F;
        end
      end
      default: begin
        if (shadow_count != 0 && $urandom_range(0, 9) < 8)
          c.index = 4'($urandom_range(0, shadow_count - 1));
      end
    endcase
    return c;
  endfunction

  // Present one command beat, hold it until the block takes it, then log the
  // status it must produce. Raise start in the same step the previous beat was
  // taken unless an idle burst comes first.
  task automatic send_beat(msc_in_t item, bit has_typed, msc_out_t typed, int unsigned gap);
    msc_out_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_command(item);
    awaited_status.push_back(has_typed ? typed : predicted);
    beats_sent++;
    if (predicted.dropped_oldest) full_appends++;
    if (predicted.removed && item.cmd == CMD_CHECK) cancel_hits++;
    if (predicted.found && !predicted.removed) dup_hits++;
    if (predicted.error) index_errors++;
  endtask

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Take every status beat at the edge that ends its strobe cycle and score it
  // against the oldest outstanding expectation.
  always @(posedge clk) begin
    msc_out_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (awaited_status.size() == 0) begin
        $error("status beat with no command waiting for it: %h", out_data);
        fail_count++;
      end else begin
        want = awaited_status.pop_front();
        check_field("slot",           want.slot,           out_data.slot);
        check_field("found",          want.found,          out_data.found);
        check_field("removed",        want.removed,        out_data.removed);
        check_field("dropped_oldest", want.dropped_oldest, out_data.dropped_oldest);
        check_field("error",          want.error,          out_data.error);
        check_field("count",          want.count,          out_data.count);
        check_field("read_type",      want.read_type,      out_data.read_type);
        check_field("read_task_id",   want.read_task_id,   out_data.read_task_id);
        check_field("read_len",       want.read_len,       out_data.read_len);
        check_field("read_handle",    want.read_handle,    out_data.read_handle);
        beats_checked++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------

  initial begin
    bit filling;
    bit bursty;
    bit calm;

    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    foreach (shadow_tbl[i]) shadow_tbl[i] = '0;
    shadow_count  = 0;
    fail_count    = 0;
    beats_sent    = 0;
    beats_checked = 0;
    full_appends  = 0;
    cancel_hits   = 0;
    dup_hits      = 0;
    index_errors  = 0;

    // Directed table. Rows on an empty table, plain appends, the full-table append
    // and the read after it carry their status typed in; the rest go through the model.
    add_row('{CMD_READ,   MT_NONE, 32'd0, 8'd0, 16'd0, 4'd0},  1, status(0, 0, 0, 0, 1, 0));
    add_row('{CMD_DELETE, MT_NONE, 32'd0, 8'd0, 16'd0, 4'd15}, 1, status(0, 0, 0, 0, 1, 0));
    add_row('{CMD_CHECK, MT_CANCEL_CALL, 32'hFFFF_FFFF, 8'd0, 16'd0, 4'd0},
            1, status(0, 0, 0, 0, 0, 0));
    // Fill the table with every type, stored as given.
    for (int k = 0; k < TBL_DEPTH; k++) begin
      add_row('{CMD_APPEND, k[2:0], 32'h1000_0000 * k + k, 8'(k * 17), 16'(k * 16'h1111),
                4'd0},
              1, status(4'(k), 0, 0, 0, 0, 5'(k + 1)));
    end
    // Append to a full table: drop the oldest, land in the top slot.
    add_row('{CMD_APPEND, MT_CALL, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 4'd0},
            1, status(4'd15, 0, 0, 1, 0, 5'd16));
    add_row('{CMD_READ, MT_NONE, 32'd0, 8'd0, 16'd0, 4'd15},
            1, '{4'd15, 1'b0, 1'b0, 1'b0, 1'b0, 5'd16, MT_CALL, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF});
    add_row('{CMD_READ,  MT_NONE,  32'd0,         8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_CALL,  32'h1000_0001, 8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_SHORT, 32'h2000_0002, 8'd0, 16'd0, 4'd0}, 0, '0);
    // Checks with none or plain types never match, even on an equal id.
    add_row('{CMD_CHECK, MT_PLAIN, 32'h5000_0005, 8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_NONE,  32'h8000_0008, 8'd0, 16'd0, 4'd0}, 0, '0);
    // Cancel call needs bit 31 set on the command's task id to match.
    add_row('{CMD_CHECK, MT_CANCEL_CALL,  32'h1000_0001, 8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_CANCEL_CALL,  32'h9000_0001, 8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_CANCEL_SHORT, 32'h2000_0002, 8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_CANCEL_SHORT, 32'h0000_1234, 8'd0, 16'd0, 4'd0}, 0, '0);
    add_row('{CMD_CHECK, MT_PLAIN_MAX,    32'h7000_0007, 8'd0, 16'd0, 4'd0}, 0, '0);
    // Delete the newest, then hit the vacated slot.
    add_row('{CMD_DELETE, MT_NONE, 32'd0, 8'd0, 16'd0, 4'd13}, 0, '0);
    add_row('{CMD_DELETE, MT_NONE, 32'd0, 8'd0, 16'd0, 4'd13}, 0, '0);
    add_row('{CMD_READ,   MT_NONE, 32'd0, 8'd0, 16'd0, 4'd15}, 0, '0);

    // Hold reset, then release it and let the block idle before the first beat.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp,
                idle_gap(1'b1));

    // Random part: sweep the table between empty and full, with idle bursts in
    // some 64-beat stretches and none in the tail.
    filling = 1'b1;
    bursty  = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) bursty = $urandom_range(0, 2) != 0;
      calm = n >= RANDOM_ITEMS - CALM_TAIL;
      if (filling && shadow_count == TBL_DEPTH && $urandom_range(0, 7) == 0) filling = 1'b0;
      if (!filling && shadow_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      send_beat(random_command(filling), 1'b0, '0, idle_gap(bursty && !calm));
    end
    start <= 1'b0;

    // Drain: wait for every owed status beat, then watch for strays.
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command beats (%0d directed), scored %0d status beats.",
             beats_sent, directed_rows.size(), beats_checked);
    $display("Full-table appends %0d, cancel hits %0d, duplicate hits %0d, index errors %0d.",
             full_appends, cancel_hits, dup_hits, index_errors);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
